// ===== src/i2cm_pkg.sv =====
// shared types and constants of the i2c bus monitor
package i2cm_pkg;

	localparam int TIME_BITS  = 32;
	localparam int STAMP_W    = 32;
	localparam logic [STAMP_W-1:0] STAMP_MASK = (TIME_BITS >= STAMP_W) ? '1 :
		STAMP_W'((64'd1 << TIME_BITS) - 64'd1);

	localparam int OPQ_DEPTH  = 4;
	localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
	localparam int RBUF_DEPTH = 2;
	localparam int RBUF_AW    = $clog2(RBUF_DEPTH);

	localparam logic [3:0] COUNT_SKIP = 4'd15;
	localparam logic [3:0] COUNT_ACK  = 4'd8;

	typedef enum logic [1:0] {
		OP_START,
		OP_STOP,
		OP_FALL
	} op_code_t;

	typedef enum logic [2:0] {
		KIND_START     = 3'd0,
		KIND_RESTART   = 3'd1,
		KIND_STOP      = 3'd2,
		KIND_LONE_STOP = 3'd3,
		KIND_BYTE      = 3'd4
	} kind_t;

	typedef struct packed {
		op_code_t           code;
		logic               sda_prev;
		logic [STAMP_W-1:0] stamp;
	} op_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         data_byte;
		logic               nack;
		logic [STAMP_W-1:0] stamp;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} opq_status_t;

endpackage

// ===== src/i2cm_op_queue.sv =====
// short queue of bus operations between the front and the back part
module i2cm_op_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  i2cm_pkg::op_t         wr_op,
	input  logic                  rd_en,
	output i2cm_pkg::op_t         rd_op,
	output i2cm_pkg::opq_status_t status
);
	import i2cm_pkg::*;

	op_t             entry_q [OPQ_DEPTH];
	logic [OPQ_AW-1:0] wr_ptr_q;
	logic [OPQ_AW-1:0] rd_ptr_q;
	logic [OPQ_AW:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign status.full  = (count_q == (OPQ_AW+1)'(OPQ_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr = wr_en && !status.full;
	assign do_rd = rd_en && !status.empty;
	assign rd_op = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_op;
	end

endmodule

// ===== src/i2cm_front.sv =====
// front part: tracks bus levels and turns change events into bus operations
module i2cm_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     scl_changed,
	input  logic                     scl_new_level,
	input  logic                     sda_changed,
	input  logic                     sda_new_level,
	input  logic [31:0]              event_time,
	input  logic                     opq_full,
	output logic                     opq_wr,
	output i2cm_pkg::op_t            opq_op
);
	import i2cm_pkg::*;

	logic scl_q;
	logic sda_q;
	logic scl_nxt;
	logic sda_nxt;
	logic accept;
	logic cond;
	logic fall;

	assign full    = opq_full;
	assign accept  = push && !opq_full;
	assign scl_nxt = scl_changed ? scl_new_level : scl_q;
	assign sda_nxt = sda_changed ? sda_new_level : sda_q;
	// sda moves while scl holds high
	assign cond    = scl_nxt && !scl_changed && sda_changed;
	assign fall    = scl_changed && !scl_nxt;

	always_comb begin
		opq_op.sda_prev = sda_q;
		opq_op.stamp    = event_time & STAMP_MASK;
		if (cond) opq_op.code = sda_nxt ? OP_STOP : OP_START;
		else      opq_op.code = OP_FALL;
		opq_wr = accept && (cond || fall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q <= 1'b0;
			sda_q <= 1'b0;
		end else if (accept) begin
			scl_q <= scl_nxt;
			sda_q <= sda_nxt;
		end
	end

endmodule

// ===== src/i2cm_back.sv =====
// back part: frame and byte decoding, with a two-entry result buffer
module i2cm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              opq_empty,
	input  i2cm_pkg::op_t     opq_op,
	output logic              opq_rd,
	input  logic              pop,
	output logic              empty,
	output i2cm_pkg::result_t res
);
	import i2cm_pkg::*;

	logic                in_frame_q;
	logic [3:0]          bit_cnt_q;
	logic [7:0]          shift_q;

	result_t             rbuf_q [RBUF_DEPTH];
	logic [RBUF_AW-1:0]  wr_ptr_q;
	logic [RBUF_AW-1:0]  rd_ptr_q;
	logic [RBUF_AW:0]    count_q;

	logic                room;
	logic                emit;
	logic                do_pop;
	result_t             res_nxt;
	logic                in_frame_nxt;
	logic [3:0]          bit_cnt_nxt;
	logic [7:0]          shift_nxt;

	assign room   = (count_q != (RBUF_AW+1)'(RBUF_DEPTH));
	assign opq_rd = room && !opq_empty;
	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign res    = rbuf_q[rd_ptr_q];

	always_comb begin
		in_frame_nxt      = in_frame_q;
		bit_cnt_nxt       = bit_cnt_q;
		shift_nxt         = shift_q;
		emit              = 1'b0;
		res_nxt.kind      = KIND_BYTE;
		res_nxt.data_byte = 8'd0;
		res_nxt.nack      = 1'b0;
		res_nxt.stamp     = opq_op.stamp;
		case (opq_op.code)
			OP_START: begin
				emit         = 1'b1;
				res_nxt.kind = in_frame_q ? KIND_RESTART : KIND_START;
				in_frame_nxt = 1'b1;
				bit_cnt_nxt  = COUNT_SKIP;
				shift_nxt    = 8'd0;
			end
			OP_STOP: begin
				emit         = 1'b1;
				res_nxt.kind = in_frame_q ? KIND_STOP : KIND_LONE_STOP;
				in_frame_nxt = 1'b0;
			end
			OP_FALL: begin
				if (bit_cnt_q < COUNT_ACK) shift_nxt = {shift_q[6:0], opq_op.sda_prev};
				if (bit_cnt_q == COUNT_ACK) begin
					emit              = 1'b1;
					res_nxt.data_byte = shift_q;
					res_nxt.nack      = opq_op.sda_prev;
					bit_cnt_nxt       = 4'd0;
					shift_nxt         = 8'd0;
				end else begin
					bit_cnt_nxt = bit_cnt_q + 4'd1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			bit_cnt_q  <= 4'd0;
			shift_q    <= 8'd0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			if (opq_rd) begin
				in_frame_q <= in_frame_nxt;
				bit_cnt_q  <= bit_cnt_nxt;
				shift_q    <= shift_nxt;
				if (emit) wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if ((opq_rd && emit) && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !(opq_rd && emit)) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (opq_rd && emit) rbuf_q[wr_ptr_q] <= res_nxt;
	end

endmodule

// ===== src/i2c_bus_monitor_top.sv =====
// top level of the passive i2c bus monitor
// Passive i2c bus monitor fed with timestamped change events of scl and sda, one request per
// clock cycle when neither side stalls. The front part keeps the bus levels and classifies each
// event as a start, a stop, an scl falling edge or nothing; events that mean nothing are dropped
// there. A four-entry operation queue parts it from the back part, which keeps the frame flag,
// the bit counter and the shift register, and writes start, repeated start, stop, stop without
// start and byte results (with the ack bit, 1 meaning nack) into a two-entry result buffer. The
// sustained rate is one event per cycle while the result side keeps taking results, set by the
// back part, which updates its state for each operation it reads; a result passes through the
// operation queue and is registered in the result buffer before it shows on the result ports.
// Bytes are assembled from falling edges even before any start has been seen, and an event that
// moves both lines at once is never a start or a stop. No clearing pass is needed after reset.
module i2c_bus_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	// event side
	input  logic        push,
	output logic        full,
	input  logic        scl_changed,
	input  logic        scl_new_level,
	input  logic        sda_changed,
	input  logic        sda_new_level,
	input  logic [31:0] event_time,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_kind,
	output logic [7:0]  data_byte,
	output logic        not_acknowledged,
	output logic [31:0] stamp
);
	import i2cm_pkg::*;

	// operation path between front and back
	logic        opq_wr;
	op_t         opq_wr_op;
	logic        opq_rd;
	op_t         opq_rd_op;
	opq_status_t opq_status;
	result_t     res;

	// front: level tracking and event classification
	i2cm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.scl_changed   (scl_changed),
		.scl_new_level (scl_new_level),
		.sda_changed   (sda_changed),
		.sda_new_level (sda_new_level),
		.event_time    (event_time),
		.opq_full      (opq_status.full),
		.opq_wr        (opq_wr),
		.opq_op        (opq_wr_op)
	);

	// decoupling queue, lets either side stall on its own
	i2cm_op_queue u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (opq_wr),
		.wr_op  (opq_wr_op),
		.rd_en  (opq_rd),
		.rd_op  (opq_rd_op),
		.status (opq_status)
	);

	// back: frame state, byte assembly and result buffer
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.opq_empty (opq_status.empty),
		.opq_op    (opq_rd_op),
		.opq_rd    (opq_rd),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	// oldest waiting result
	assign event_kind       = res.kind;
	assign data_byte        = res.data_byte;
	assign not_acknowledged = res.nack;
	assign stamp            = res.stamp;

endmodule

// ===== src/i2cm_checker.sv =====
// port-level checks of the i2c bus monitor, bound to the top level
module i2cm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  event_kind,
	input logic [7:0]  data_byte,
	input logic        not_acknowledged,
	input logic [31:0] stamp
);
	import i2cm_pkg::*;

	// queues come out of reset empty on both sides
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> (empty && !full))
		else $error("monitor not idle in reset");

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(data_byte)
			&& $stable(not_acknowledged) && $stable(stamp)))
		else $error("waiting result changed or vanished");

	// only bytes carry data and an ack bit
	a_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (event_kind != KIND_BYTE)) |-> (data_byte == 8'd0 && !not_acknowledged))
		else $error("data on a non-byte result");

	// the event side only fills up after a request was offered
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

endmodule

bind i2c_bus_monitor_top i2cm_checker u_chk (.*);

// ===== test/tb_i2c_bus_monitor_top.sv =====
// self-checking testbench of the passive i2c bus monitor top level
module tb_i2c_bus_monitor_top;

	import i2cm_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        scl_changed;
	logic        scl_new_level;
	logic        sda_changed;
	logic        sda_new_level;
	logic [31:0] event_time;
	logic        empty;
	logic        pop;
	logic [2:0]  event_kind;
	logic [7:0]  data_byte;
	logic        not_acknowledged;
	logic [31:0] stamp;

	// decoder state as the bus monitor should hold it
	logic        bus_scl;
	logic        bus_sda;
	logic        frame_open;
	logic [3:0]  edge_count;
	logic [7:0]  shift_reg;

	// results still owed by the block, oldest first
	result_t     pending_results[$];

	int          fail_count    = 0;
	int          items_sent    = 0;
	logic [31:0] stamp_clock   = 32'd0;
	// sender runs without gaps while set
	bit          tx_quiet      = 1'b0;
	// receiver stall and no-stall counters, all in cycles
	int          hold_left     = 0;
	int          rx_idle_left  = 0;
	int          rx_quiet_left = 0;

	i2c_bus_monitor_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.scl_changed      (scl_changed),
		.scl_new_level    (scl_new_level),
		.sda_changed      (sda_changed),
		.sda_new_level    (sda_new_level),
		.event_time       (event_time),
		.empty            (empty),
		.pop              (pop),
		.event_kind       (event_kind),
		.data_byte        (data_byte),
		.not_acknowledged (not_acknowledged),
		.stamp            (stamp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// timestamps mostly climb, sometimes jump anywhere in the 32-bit range
	function automatic logic [31:0] next_stamp();
		if ($urandom_range(0, 29) == 0)
			stamp_clock = $urandom();
		else
			stamp_clock = stamp_clock + 32'($urandom_range(1, 500));
		return stamp_clock;
	endfunction

	// advance the decoder by one accepted request and queue what it must report
	function automatic void decode_event(input logic sc, input logic sn, input logic dc,
		input logic dn, input logic [31:0] t);
		logic    sda_before;
		result_t r;
		sda_before = bus_sda;
		r = '0;
		r.stamp = t & STAMP_MASK;
		if (sc)
			bus_scl = sn;
		if (dc)
			bus_sda = dn;
		// sda moving alone while scl is high marks a start or a stop
		if (bus_scl && !sc && dc) begin
			if (!bus_sda) begin
				if (frame_open)
					r.kind = KIND_RESTART;
				else
					r.kind = KIND_START;
				frame_open = 1'b1;
				edge_count = COUNT_SKIP;
				shift_reg  = 8'h00;
			end else begin
				if (frame_open)
					r.kind = KIND_STOP;
				else
					r.kind = KIND_LONE_STOP;
				frame_open = 1'b0;
			end
			pending_results.push_back(r);
		end
		// every reported low scl is a falling edge, even a repeated one
		if (sc && !bus_scl) begin
			if (edge_count < COUNT_ACK)
				shift_reg = {shift_reg[6:0], sda_before};
			if (edge_count == COUNT_ACK) begin
				r.kind      = KIND_BYTE;
				r.data_byte = shift_reg;
				r.nack      = sda_before;
				pending_results.push_back(r);
				edge_count  = 4'd0;
				shift_reg   = 8'h00;
			end else begin
				edge_count = edge_count + 4'd1;
			end
		end
	endfunction

	// offer one request, hold it until accepted, then maybe leave a gap
	task automatic send_event(input logic sc, input logic sn, input logic dc, input logic dn,
		input logic [31:0] t);
		int gap;
		push          <= 1'b1;
		scl_changed   <= sc;
		scl_new_level <= sn;
		sda_changed   <= dc;
		sda_new_level <= dn;
		event_time    <= t;
		do
			@(posedge clk);
		while (full);
		decode_event(sc, sn, dc, dn, t);
		if (sc || dc)
			items_sent++;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed result has been taken
	task automatic wait_drained();
		if (push)
			push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// scl only moves when it really changes, so a frame is never disturbed
	task automatic drive_scl(input logic v);
		if (bus_scl != v)
			send_event(1'b1, v, 1'b0, 1'b0, next_stamp());
	endtask

	// sda moves only when it changes, apart from a rare repeated report while scl is low, which is harmless then
	task automatic drive_sda(input logic v);
		if (bus_sda != v || (!bus_scl && $urandom_range(0, 9) == 0))
			send_event(1'b0, 1'b0, 1'b1, v, next_stamp());
	endtask

	// any combination of flags, levels and timestamp
	task automatic send_noise();
		send_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
	endtask

	// start, a few bytes with ack bit, then a repeated start or a stop;
	// now and then the last byte is cut short
	task automatic send_frame();
		int         n_bytes;
		int         n_bits;
		bit         restart;
		logic [8:0] bits;
		if (!bus_sda) begin
			drive_scl(1'b0);
			drive_sda(1'b1);
		end
		drive_scl(1'b1);
		do begin
			send_event(1'b0, 1'b0, 1'b1, 1'b0, next_stamp());
			drive_scl(1'b0);
			n_bytes = $urandom_range(1, 3);
			for (int b = 0; b < n_bytes; b++) begin
				bits   = 9'($urandom());
				n_bits = 9;
				if (b == n_bytes - 1 && $urandom_range(0, 9) == 0)
					n_bits = $urandom_range(0, 8);
				for (int i = 0; i < n_bits; i++) begin
					drive_sda(bits[8-i]);
					drive_scl(1'b1);
					drive_scl(1'b0);
				end
			end
			restart = ($urandom_range(0, 3) == 0);
			if (restart) begin
				drive_sda(1'b1);
				drive_scl(1'b1);
			end else begin
				drive_sda(1'b0);
				drive_scl(1'b1);
				drive_sda(1'b1);
			end
		end while (restart);
	endtask

	// compare one taken result with the oldest owed one
	task automatic check_result();
		result_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request behind it: event_kind %0d stamp %0h",
				event_kind, stamp);
			fail_count++;
		end else begin
			want = pending_results.pop_front();
			if (event_kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
				fail_count++;
			end
			if (data_byte !== want.data_byte) begin
				$error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
				fail_count++;
			end
			if (not_acknowledged !== want.nack) begin
				$error("not_acknowledged: expected %0b, got %0b", want.nack,
					not_acknowledged);
				fail_count++;
			end
			if (stamp !== want.stamp) begin
				$error("stamp: expected %0h, got %0h", want.stamp, stamp);
				fail_count++;
			end
		end
	endtask

	// each special case of the decoder once, with the timestamp extremes
	task automatic test_directed();
		// stop with no open start: raise scl, then raise sda while scl stays high
		send_event(1'b1, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
		send_event(1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		// a byte before any start, clocked by one real fall and eight repeated low reports
		send_event(1'b1, 1'b0, 1'b0, 1'b0, next_stamp());
		repeat (8) send_event(1'b1, 1'b0, 1'b0, 1'b0, next_stamp());
		// both lines at once: sda falls as scl rises, no start
		send_event(1'b1, 1'b1, 1'b1, 1'b0, next_stamp());
		// both lines at once again: the scl fall samples the old sda
		send_event(1'b1, 1'b0, 1'b1, 1'b1, next_stamp());
		// start, skipped edge, repeated start, stop
		send_event(1'b1, 1'b1, 1'b0, 1'b0, next_stamp());
		send_event(1'b0, 1'b0, 1'b1, 1'b0, next_stamp());
		send_event(1'b1, 1'b0, 1'b0, 1'b0, next_stamp());
		send_event(1'b0, 1'b0, 1'b1, 1'b1, next_stamp());
		send_event(1'b1, 1'b1, 1'b0, 1'b0, next_stamp());
		send_event(1'b0, 1'b0, 1'b1, 1'b0, 32'h0000_0000);
		send_event(1'b0, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// receiver holds off for a long stretch while starts and stops keep coming
	task automatic test_full_stall();
		tx_quiet  = 1'b1;
		drive_scl(1'b1);
		hold_left = 400;
		repeat (30) begin
			send_event(1'b0, 1'b0, 1'b1, 1'b0, next_stamp());
			send_event(1'b0, 1'b0, 1'b1, 1'b1, next_stamp());
		end
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// mostly well-formed frames, some noise, and pauses until all is drained
	task automatic test_random_traffic();
		int goal;
		int pick;
		goal = 1650;
		while (items_sent < goal) begin
			tx_quiet = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 14)
				send_frame();
			else if (pick < 19)
				repeat ($urandom_range(1, 6)) send_noise();
			else
				wait_drained();
		end
		tx_quiet = 1'b0;
	endtask

	// result side: take a result whenever pop meets a non-empty buffer
	initial begin
		int n;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				check_result();
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_idle_left > 0) begin
				rx_idle_left--;
				pop <= 1'b0;
			end else begin
				// now and then a long stretch without any stall
				if (rx_quiet_left > 0)
					rx_quiet_left--;
				else if ($urandom_range(0, 299) == 0)
					rx_quiet_left = 200;
				n = (rx_quiet_left > 0) ? 0 : pick_gap();
				if (n > 0) begin
					rx_idle_left = n - 1;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	// request side and the end of the run
	initial begin
		int drain_wait;
		arst_n        <= 1'b0;
		push          <= 1'b0;
		scl_changed   <= 1'b0;
		scl_new_level <= 1'b0;
		sda_changed   <= 1'b0;
		sda_new_level <= 1'b0;
		event_time    <= 32'd0;
		bus_scl    = 1'b0;
		bus_sda    = 1'b0;
		frame_open = 1'b0;
		edge_count = 4'd0;
		shift_reg  = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_stall();
		test_random_traffic();

		// let the last results come out, with a bound
		if (push)
			push <= 1'b0;
		drain_wait = 0;
		while (pending_results.size() != 0 && drain_wait < 20000) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("i2c_bus_monitor_top test passed");
		else
			$display("i2c_bus_monitor_top test failed");
		$finish;
	end

	// watchdog far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("i2c_bus_monitor_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/i2cm_pkg.sv
src/i2cm_op_queue.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_bus_monitor_top.sv
src/i2cm_checker.sv
test/tb_i2c_bus_monitor_top.sv
